// File: rtl/core/stbs_pkg.sv
// shared constants and types for the sorted table binary search block
package stbs_pkg;

    localparam int TABLE_DEPTH = 1024;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int LEN_W       = $clog2(TABLE_DEPTH + 1);
    localparam int DATA_W      = 32;
    localparam int EIDX_W      = 10;
    localparam int CNT_W       = 11;
    localparam int HIDX_W      = 10;

    localparam int S_TDATA_W   = 80;
    localparam int M_TDATA_W   = 16;
    localparam int APB_AW      = 3;
    localparam int APB_DW      = 32;

    localparam logic             ACT_WRITE     = 1'b0;
    localparam logic             ACT_SEARCH    = 1'b1;
    localparam logic             REG_ENTRIES   = 1'b0;
    localparam logic [CNT_W-1:0] ENTRIES_RESET = 11'd1024;

    typedef struct packed {
        logic              we;
        logic [IDX_W-1:0]  addr;
        logic [DATA_W-1:0] wdata;
    } ram_req_t;

endpackage

// File: rtl/core/stbs_ram.sv
// generic single-port ram with registered read
module stbs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata_reg <= mem[addr];
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/core/stbs_search.sv
// search sequencer: table writes, probe loop and result register
module stbs_search
    import stbs_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic              action,
    input  logic [EIDX_W-1:0] entry_index,
    input  logic [DATA_W-1:0] entry_value,
    input  logic [DATA_W-1:0] target_value,
    input  logic [CNT_W-1:0]  entries_in_use,
    output ram_req_t          ram_req,
    input  logic [DATA_W-1:0] ram_rdata,
    output logic              out_valid,
    input  logic              out_ready,
    output logic              hit,
    output logic [HIDX_W-1:0] hit_index
);

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_PROBE = 3'b010,
        ST_DONE  = 3'b100
    } state_t;

    state_t             state_reg, state_next;
    logic [LEN_W-1:0]   lo_reg, lo_next;
    logic [LEN_W-1:0]   hi_reg, hi_next;
    logic [IDX_W-1:0]   mid_reg, mid_next;
    logic [DATA_W-1:0]  target_reg, target_next;
    logic               res_hit_reg, res_hit_next;
    logic [IDX_W-1:0]   res_idx_reg, res_idx_next;
    logic               out_valid_reg, out_valid_next;
    logic               out_hit_reg, out_hit_next;
    logic [HIDX_W-1:0]  out_idx_reg, out_idx_next;

    logic               accept;
    logic [LEN_W-1:0]   n_live;
    logic [LEN_W-1:0]   n_m1;
    logic [LEN_W-1:0]   mid_ext;
    logic [LEN_W:0]     sum_l;
    logic [LEN_W:0]     sum_g;
    logic [LEN_W-1:0]   lo_l;
    logic               empty_l;
    logic               empty_g;
    logic               is_eq;
    logic               is_less;
    logic               slot_free;

    assign in_ready  = (state_reg == ST_IDLE);
    assign accept    = in_valid && in_ready;
    assign slot_free = !out_valid_reg || out_ready;

    // live range is [lo, hi), hi exclusive
    always_comb
    begin
        if (32'(entries_in_use) > 32'(TABLE_DEPTH))
        begin
            n_live = LEN_W'(TABLE_DEPTH);
        end
        else
        begin
            n_live = LEN_W'(entries_in_use);
        end
    end

    assign n_m1    = n_live - LEN_W'(1);
    assign mid_ext = LEN_W'(mid_reg);
    // both candidate midpoints are ready before the compare resolves
    assign lo_l    = mid_ext + LEN_W'(1);
    assign empty_l = (lo_l >= hi_reg);
    assign empty_g = (lo_reg >= mid_ext);
    assign sum_l   = {1'b0, mid_ext} + {1'b0, hi_reg};
    assign sum_g   = {1'b0, lo_reg} + {1'b0, mid_ext} - (LEN_W + 1)'(1);
    assign is_eq   = (ram_rdata == target_reg);
    assign is_less = ($signed(ram_rdata) < $signed(target_reg));

    always_comb
    begin
        state_next     = state_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        mid_next       = mid_reg;
        target_next    = target_reg;
        res_hit_next   = res_hit_reg;
        res_idx_next   = res_idx_reg;
        out_valid_next = out_valid_reg;
        out_hit_next   = out_hit_reg;
        out_idx_next   = out_idx_reg;
        ram_req.we     = 1'b0;
        ram_req.addr   = mid_reg;
        ram_req.wdata  = entry_value;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (action == ACT_WRITE)
                    begin
                        ram_req.we   = (32'(entry_index) < 32'(TABLE_DEPTH));
                        ram_req.addr = IDX_W'(entry_index);
                    end
                    else
                    begin
                        target_next = target_value;
                        lo_next     = '0;
                        hi_next     = n_live;
                        mid_next    = IDX_W'(n_m1 >> 1);
                        ram_req.addr = IDX_W'(n_m1 >> 1);
                        if (n_live == '0)
                        begin
                            res_hit_next = 1'b0;
                            res_idx_next = '0;
                            state_next   = ST_DONE;
                        end
                        else
                        begin
                            state_next = ST_PROBE;
                        end
                    end
                end
            end
            ST_PROBE:
            begin
                if (is_eq)
                begin
                    res_hit_next = 1'b1;
                    res_idx_next = mid_reg;
                    state_next   = ST_DONE;
                end
                else if (is_less)
                begin
                    lo_next      = lo_l;
                    mid_next     = IDX_W'(sum_l >> 1);
                    ram_req.addr = IDX_W'(sum_l >> 1);
                    if (empty_l)
                    begin
                        res_hit_next = 1'b0;
                        res_idx_next = '0;
                        state_next   = ST_DONE;
                    end
                end
                else
                begin
                    hi_next      = mid_ext;
                    mid_next     = IDX_W'(sum_g >> 1);
                    ram_req.addr = IDX_W'(sum_g >> 1);
                    if (empty_g)
                    begin
                        res_hit_next = 1'b0;
                        res_idx_next = '0;
                        state_next   = ST_DONE;
                    end
                end
            end
            ST_DONE:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    out_hit_next   = res_hit_reg;
                    out_idx_next   = HIDX_W'(res_idx_reg);
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lo_reg      <= lo_next;
        hi_reg      <= hi_next;
        mid_reg     <= mid_next;
        target_reg  <= target_next;
        res_hit_reg <= res_hit_next;
        res_idx_reg <= res_idx_next;
        out_hit_reg <= out_hit_next;
        out_idx_reg <= out_idx_next;
    end

    assign out_valid = out_valid_reg;
    assign hit       = out_hit_reg;
    assign hit_index = out_idx_reg;

    a_write_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
        ram_req.we |-> (state_reg == ST_IDLE))
        else $error("table write outside idle");

    a_range_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_PROBE) |-> (lo_reg < hi_reg))
        else $error("probing an empty range");

    a_mid_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_PROBE) |-> (mid_ext >= lo_reg && mid_ext < hi_reg))
        else $error("probe outside live range");

    a_miss_index_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_hit_reg) |-> (out_idx_reg == '0))
        else $error("miss with nonzero index");

    a_result_after_done: assert property (@(posedge clk) disable iff (!rst_n)
        ($rose(out_valid_reg)) |-> ($past(state_reg) == ST_DONE))
        else $error("result loaded outside done");

endmodule

// File: rtl/core/sorted_table_binary_search.sv
// top level: stream ports, register port, table ram and search sequencer
//
//  channel  | direction | handshake          | payload
//  ---------+-----------+--------------------+------------------------------------------
//  s_*      | in        | s_tvalid/s_tready  | tuser: action; tdata: index, value, target
//  m_*      | out       | m_tvalid/m_tready  | tuser: hit; tdata: hit_index
//  apb      | in        | psel/penable       | entries_in_use at address 0
//
//  a table write goes to the ram in its accept cycle; a search has an accept step,
//  up to log2(depth)+1 probes through the single ram read port, and a load of the
//  result register that waits until the output register is free
//  a stalled result holds in the output register while the next search proceeds
//  rst_n clears control state only; table entries are undefined until written
module sorted_table_binary_search
    import stbs_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // [9:0] entry_index, [41:10] entry_value, [73:42] target_value, rest zero
    input  logic [S_TDATA_W-1:0] s_tdata,
    // [0] action
    input  logic [0:0]           s_tuser,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // [9:0] hit_index, rest zero
    output logic [M_TDATA_W-1:0] m_tdata,
    // [0] hit
    output logic [0:0]           m_tuser,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [APB_AW-1:0]    paddr,
    input  logic [APB_DW-1:0]    pwdata,
    output logic [APB_DW-1:0]    prdata,
    output logic                 pready
);

    logic [CNT_W-1:0]  entries_reg, entries_next;
    ram_req_t          ram_req;
    logic [DATA_W-1:0] ram_rdata;
    logic              res_hit;
    logic [HIDX_W-1:0] res_idx;
    logic              reg_sel;

    assign pready  = 1'b1;
    assign reg_sel = (paddr[2] == REG_ENTRIES);

    always_comb
    begin
        entries_next = entries_reg;
        if (psel && penable && pwrite && reg_sel)
        begin
            entries_next = pwdata[CNT_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entries_reg <= ENTRIES_RESET;
        end
        else
        begin
            entries_reg <= entries_next;
        end
    end

    assign prdata = reg_sel ? APB_DW'(entries_reg) : '0;

    stbs_ram #(
        .WIDTH (DATA_W),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .clk   (clk),
        .we    (ram_req.we),
        .addr  (ram_req.addr),
        .wdata (ram_req.wdata),
        .rdata (ram_rdata)
    );

    stbs_search u_search (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (s_tvalid),
        .in_ready       (s_tready),
        .action         (s_tuser[0]),
        .entry_index    (s_tdata[9:0]),
        .entry_value    (s_tdata[41:10]),
        .target_value   (s_tdata[73:42]),
        .entries_in_use (entries_reg),
        .ram_req        (ram_req),
        .ram_rdata      (ram_rdata),
        .out_valid      (m_tvalid),
        .out_ready      (m_tready),
        .hit            (res_hit),
        .hit_index      (res_idx)
    );

    assign m_tuser = res_hit;
    assign m_tdata = {(M_TDATA_W - HIDX_W)'(0), res_idx};

endmodule
